// ===== rtl/wip_pkg.sv =====
package wip_pkg;

    localparam int NUM_CATEGORIES = 32;
    localparam int LOG_SHIFT      = 3;

    localparam int OPC_W      = 2;
    localparam int CAT_W      = 5;
    localparam int TS_W       = 64;
    localparam int SUM_W      = 32;
    localparam int POS_W      = LOG_SHIFT;
    localparam int LOG_ADDR_W = CAT_W + POS_W;
    localparam int LOG_DEPTH  = NUM_CATEGORIES << LOG_SHIFT;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [OPC_W-1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_CLOSE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        t_op             op;
        logic            cat_ok;
        logic [CAT_W-1:0] cat;
        logic [TS_W-1:0]  ts;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_READ,
        BS_EXEC
    } t_bstate;

endpackage

// ===== rtl/wip_front.sv =====
module wip_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wip_pkg::OPC_W-1:0]    i_opcode,
    input  logic [wip_pkg::CAT_W-1:0]    i_category,
    input  logic [wip_pkg::TS_W-1:0]     i_timestamp,
    input  logic                         i_pop,
    output logic                         o_busy,
    output logic                         o_cmd_valid,
    output wip_pkg::t_cmd                o_cmd
);

    wip_pkg::t_cmd                    r_q [wip_pkg::QUEUE_DEPTH];
    logic [wip_pkg::QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [wip_pkg::QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [wip_pkg::QCNT_W-1:0]       r_count, n_count;
    logic                             push;
    logic                             pop;
    wip_pkg::t_cmd                    cmd_in;

    // classify the incoming transaction
    always_comb begin
        cmd_in.op     = wip_pkg::t_op'(i_opcode);
        cmd_in.cat_ok = (wip_pkg::CAT_W+1)'(i_category)
                        < (wip_pkg::CAT_W+1)'(wip_pkg::NUM_CATEGORIES);
        cmd_in.cat    = i_category;
        cmd_in.ts     = i_timestamp;
    end

    assign o_busy      = (r_count == wip_pkg::QCNT_W'(wip_pkg::QUEUE_DEPTH));
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// ===== rtl/wip_back.sv =====
module wip_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  wip_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [wip_pkg::TS_W-1:0]      o_accumulated_time,
    output logic [wip_pkg::SUM_W-1:0]     o_window_sum,
    output logic [wip_pkg::SUM_W-1:0]     o_window_average
);

    wip_pkg::t_bstate r_state, n_state;
    wip_pkg::t_cmd    r_cmd;

    // per-category state, flops with reset
    logic [wip_pkg::TS_W-1:0]  r_stamp_mem [wip_pkg::NUM_CATEGORIES];
    logic [wip_pkg::TS_W-1:0]  r_total_mem [wip_pkg::NUM_CATEGORIES];
    logic [wip_pkg::SUM_W-1:0] r_sum_mem   [wip_pkg::NUM_CATEGORIES];
    logic [wip_pkg::POS_W-1:0] r_pos_mem   [wip_pkg::NUM_CATEGORIES];

    // frame log memory with a valid bit per entry
    logic [wip_pkg::SUM_W-1:0]     r_log_mem [wip_pkg::LOG_DEPTH];
    logic [wip_pkg::LOG_DEPTH-1:0] r_log_vld;
    logic [wip_pkg::SUM_W-1:0]     r_log_q;
    logic                          r_log_q_vld;
    logic [wip_pkg::LOG_ADDR_W-1:0] log_rd_addr;
    logic [wip_pkg::LOG_ADDR_W-1:0] log_wr_addr;

    // operands captured in the read step
    logic [wip_pkg::TS_W-1:0]  r_elapsed;
    logic [wip_pkg::TS_W-1:0]  r_total;
    logic [wip_pkg::SUM_W-1:0] r_sum;
    logic [wip_pkg::POS_W-1:0] r_pos;

    logic                      pop;
    logic                      rd_step;
    logic                      ex_step;
    logic                      wr_en;
    logic [wip_pkg::TS_W-1:0]  new_total;
    logic [wip_pkg::SUM_W-1:0] new_sum;
    logic [wip_pkg::SUM_W-1:0] old_entry;
    logic [wip_pkg::SUM_W-1:0] fresh;

    logic                      r_res_valid;
    logic [wip_pkg::TS_W-1:0]  r_res_total;
    logic [wip_pkg::SUM_W-1:0] r_res_sum;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wip_pkg::BS_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = wip_pkg::BS_READ;
                end
            end
            wip_pkg::BS_READ: begin
                n_state = wip_pkg::BS_EXEC;
            end
            wip_pkg::BS_EXEC: begin
                n_state = i_cmd_valid ? wip_pkg::BS_READ : wip_pkg::BS_IDLE;
            end
            default: begin
                n_state = wip_pkg::BS_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        pop     = 1'b0;
        rd_step = 1'b0;
        ex_step = 1'b0;
        unique case (r_state)
            wip_pkg::BS_IDLE: begin
                pop = i_cmd_valid;
            end
            wip_pkg::BS_READ: begin
                rd_step = 1'b1;
            end
            wip_pkg::BS_EXEC: begin
                ex_step = 1'b1;
                pop     = i_cmd_valid;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wip_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
    end

    assign log_rd_addr = {r_cmd.cat, r_pos_mem[r_cmd.cat]};
    assign log_wr_addr = {r_cmd.cat, r_pos};

    always_ff @(posedge i_clk) begin
        if (rd_step) begin
            r_elapsed <= r_cmd.ts - r_stamp_mem[r_cmd.cat];
            r_total   <= r_total_mem[r_cmd.cat];
            r_sum     <= r_sum_mem[r_cmd.cat];
            r_pos     <= r_pos_mem[r_cmd.cat];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_step) begin
            r_log_q <= r_log_mem[log_rd_addr];
        end
        if (wr_en) begin
            r_log_mem[log_wr_addr] <= fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_vld   <= '0;
            r_log_q_vld <= 1'b0;
        end else begin
            if (rd_step) begin
                r_log_q_vld <= r_log_vld[log_rd_addr];
            end
            if (wr_en) begin
                r_log_vld[log_wr_addr] <= 1'b1;
            end
        end
    end

    // execute step
    assign old_entry = r_log_q_vld ? r_log_q : '0;
    assign fresh     = r_total[wip_pkg::SUM_W-1:0];
    assign wr_en     = ex_step && r_cmd.cat_ok && (r_cmd.op == wip_pkg::OP_CLOSE);

    always_comb begin
        new_total = r_total;
        new_sum   = r_sum;
        case (r_cmd.op)
            wip_pkg::OP_END: begin
                new_total = r_total + r_elapsed;
            end
            wip_pkg::OP_CLOSE: begin
                new_total = '0;
                new_sum   = r_sum - old_entry + fresh;
            end
            default: begin
                new_total = r_total;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wip_pkg::NUM_CATEGORIES; k++) begin
                r_stamp_mem[k] <= '0;
                r_total_mem[k] <= '0;
                r_sum_mem[k]   <= '0;
                r_pos_mem[k]   <= '0;
            end
        end else if (ex_step && r_cmd.cat_ok) begin
            if (r_cmd.op == wip_pkg::OP_START) begin
                r_stamp_mem[r_cmd.cat] <= r_cmd.ts;
            end
            r_total_mem[r_cmd.cat] <= new_total;
            r_sum_mem[r_cmd.cat]   <= new_sum;
            if (r_cmd.op == wip_pkg::OP_CLOSE) begin
                // ring walks downward and wraps
                r_pos_mem[r_cmd.cat] <= r_pos - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= ex_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_step) begin
            r_res_total <= r_cmd.cat_ok ? new_total : '0;
            r_res_sum   <= r_cmd.cat_ok ? new_sum : '0;
        end
    end

    assign o_valid            = r_res_valid;
    assign o_accumulated_time = r_res_total;
    assign o_window_sum       = r_res_sum;
    assign o_window_average   = r_res_sum >> wip_pkg::LOG_SHIFT;

    a_read_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wip_pkg::BS_READ |=> r_state == wip_pkg::BS_EXEC)
        else $error("read step not followed by execute step");

    a_result_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_step |=> r_res_valid)
        else $error("execute step produced no result");

    a_close_clears_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_total_mem[$past(r_cmd.cat)] == '0)
        else $error("close left accumulator nonzero");

    a_close_steps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_pos_mem[$past(r_cmd.cat)] == $past(r_pos) - 1'b1)
        else $error("ring position did not step down");

    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_state == wip_pkg::BS_IDLE || r_state == wip_pkg::BS_EXEC))
        else $error("queue popped while an item is in flight");

endmodule

// ===== rtl/windowed_interval_profiler_unit.sv =====
// Each accepted start is queued; the back end pops one transaction at a time, runs
// its read and execute steps over the per-category state and the frame log memory,
// and pops the next during the execute step. The result register strobes o_valid.
// A 2-entry queue decouples intake; busy is high while it is full.
// Reset (i_rst_n low, synchronous) clears the queue, all per-category state
// and the frame log valid bits at once; the receiver cannot stall results.
module windowed_interval_profiler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [wip_pkg::OPC_W-1:0]     i_opcode,
    input  logic [wip_pkg::CAT_W-1:0]     i_category,
    input  logic [wip_pkg::TS_W-1:0]      i_timestamp,
    output logic                          o_valid,
    output logic [wip_pkg::TS_W-1:0]      o_accumulated_time,
    output logic [wip_pkg::SUM_W-1:0]     o_window_sum,
    output logic [wip_pkg::SUM_W-1:0]     o_window_average
);

    wip_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          pop;

    wip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_opcode    (i_opcode),
        .i_category  (i_category),
        .i_timestamp (i_timestamp),
        .i_pop       (pop),
        .o_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    wip_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd_valid        (cmd_valid),
        .i_cmd              (cmd),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .o_accumulated_time (o_accumulated_time),
        .o_window_sum       (o_window_sum),
        .o_window_average   (o_window_average)
    );

endmodule
